/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the next cycle, ignored while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Same form, also checked across reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/japq_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// japq_pkg: shared types and constants
// Operation codes, event codes and cell control types of the job queue.
// ---------------------------------------------------------------------------
package japq_pkg;

    localparam int WAIT_DEPTH_DEF  = 16;
    localparam int RUN_DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF     = 32;
    localparam int HANDLE_BITS_DEF = 16;

    localparam int MODE_W     = 3;
    localparam int PRIO_W     = 8;
    localparam int EV_W       = 3;
    localparam int OUT_HDL_W  = 16;
    localparam int MAXRUN_W   = 5;
    localparam int CFG_ADDR_W = 3;
    localparam int OUT_DATA_W = 24;

    localparam logic [MAXRUN_W-1:0]   MAXRUN_RESET     = 5'd4;
    localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_RUNNING = 3'd0;

    localparam logic [MODE_W-1:0] MODE_SUBMIT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ABORT    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DONE     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_START    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SHUTDOWN = 3'd4;

    localparam logic [EV_W-1:0] EV_START   = 3'd0;
    localparam logic [EV_W-1:0] EV_QUEUED  = 3'd1;
    localparam logic [EV_W-1:0] EV_DUPE    = 3'd2;
    localparam logic [EV_W-1:0] EV_FULL    = 3'd3;
    localparam logic [EV_W-1:0] EV_ABORT_Q = 3'd4;
    localparam logic [EV_W-1:0] EV_ABORT_R = 3'd5;

    typedef enum logic [1:0] {
        WOP_HOLD   = 2'd0,
        WOP_INSERT = 2'd1,
        WOP_REMOVE = 2'd2
    } t_wop;

    typedef enum logic [1:0] {
        ROP_HOLD   = 2'd0,
        ROP_PUSH   = 2'd1,
        ROP_REMOVE = 2'd2
    } t_rop;

endpackage

/* src/japq_wait_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// japq_wait_cell: one slot of the priority-ordered waiting list
// Holds id, handle and priority; shifts toward either neighbor on insert or
// remove and compares its id and priority against the current key.
// ---------------------------------------------------------------------------
module japq_wait_cell #(
    parameter int IDX         = 0,
    parameter int PW          = 4,
    parameter int ID_BITS     = japq_pkg::ID_BITS_DEF,
    parameter int HANDLE_BITS = japq_pkg::HANDLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  japq_pkg::t_wop           i_op,
    input  logic [PW-1:0]            i_pos,
    input  logic [ID_BITS-1:0]       i_new_id,
    input  logic [HANDLE_BITS-1:0]   i_new_handle,
    input  logic [japq_pkg::PRIO_W-1:0] i_new_prio,
    input  logic [ID_BITS-1:0]       i_left_id,
    input  logic [HANDLE_BITS-1:0]   i_left_handle,
    input  logic [japq_pkg::PRIO_W-1:0] i_left_prio,
    input  logic [ID_BITS-1:0]       i_right_id,
    input  logic [HANDLE_BITS-1:0]   i_right_handle,
    input  logic [japq_pkg::PRIO_W-1:0] i_right_prio,
    input  logic [ID_BITS-1:0]       i_key_id,
    input  logic [japq_pkg::PRIO_W-1:0] i_key_prio,
    output logic [ID_BITS-1:0]       o_id,
    output logic [HANDLE_BITS-1:0]   o_handle,
    output logic [japq_pkg::PRIO_W-1:0] o_prio,
    output logic                     o_id_hit,
    output logic                     o_prio_le
);
    import japq_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [ID_BITS-1:0]     r_id;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [PRIO_W-1:0]      r_prio;

    always_ff @(posedge i_clk) begin
        case (i_op)
            WOP_INSERT: begin
                if (MY_IDX > i_pos) begin
                    r_id     <= i_left_id;
                    r_handle <= i_left_handle;
                    r_prio   <= i_left_prio;
                end else if (MY_IDX == i_pos) begin
                    r_id     <= i_new_id;
                    r_handle <= i_new_handle;
                    r_prio   <= i_new_prio;
                end
            end
            WOP_REMOVE: begin
                if (MY_IDX >= i_pos) begin
                    r_id     <= i_right_id;
                    r_handle <= i_right_handle;
                    r_prio   <= i_right_prio;
                end
            end
            default: ;
        endcase
    end

    assign o_id      = r_id;
    assign o_handle  = r_handle;
    assign o_prio    = r_prio;
    assign o_id_hit  = (r_id == i_key_id);
    assign o_prio_le = (r_prio <= i_key_prio);

endmodule

/* src/japq_run_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// japq_run_cell: one slot of the running set
// Holds id and handle in start order; takes a pushed job or its right
// neighbor on removal and matches against id and handle keys.
// ---------------------------------------------------------------------------
module japq_run_cell #(
    parameter int IDX         = 0,
    parameter int PW          = 4,
    parameter int ID_BITS     = japq_pkg::ID_BITS_DEF,
    parameter int HANDLE_BITS = japq_pkg::HANDLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  japq_pkg::t_rop         i_op,
    input  logic [PW-1:0]          i_pos,
    input  logic [ID_BITS-1:0]     i_new_id,
    input  logic [HANDLE_BITS-1:0] i_new_handle,
    input  logic [ID_BITS-1:0]     i_right_id,
    input  logic [HANDLE_BITS-1:0] i_right_handle,
    input  logic [ID_BITS-1:0]     i_key_id,
    input  logic [HANDLE_BITS-1:0] i_key_handle,
    output logic [ID_BITS-1:0]     o_id,
    output logic [HANDLE_BITS-1:0] o_handle,
    output logic                   o_id_hit,
    output logic                   o_handle_hit
);
    import japq_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [ID_BITS-1:0]     r_id;
    logic [HANDLE_BITS-1:0] r_handle;

    always_ff @(posedge i_clk) begin
        case (i_op)
            ROP_PUSH: begin
                if (MY_IDX == i_pos) begin
                    r_id     <= i_new_id;
                    r_handle <= i_new_handle;
                end
            end
            ROP_REMOVE: begin
                if (MY_IDX >= i_pos) begin
                    r_id     <= i_right_id;
                    r_handle <= i_right_handle;
                end
            end
            default: ;
        endcase
    end

    assign o_id         = r_id;
    assign o_handle     = r_handle;
    assign o_id_hit     = (r_id == i_key_id);
    assign o_handle_hit = (r_handle == i_key_handle);

endmodule

/* src/job_admission_priority_queue_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// job_admission_priority_queue_core: job admission with priority waiting list
// Jobs are submitted, aborted, retired, promoted or flushed through one
// command stream; each command yields zero or more event transfers.
// ---------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_axis group (mode, id, handle, priority in tdata).
//   Events leave on the m_axis group (event code and handle in tdata, tlast
//   marks the final event of a command). max_running is written over APB.
//   One command at a time: accept, compare (all cells match their keys in
//   parallel), execute. Submit, abort and done finish in the execute state;
//   submit and abort register any event they give there. Start-more and
//   shutdown then drain the head cells at one event per cycle while the
//   receiver takes them, and return to idle once nothing is left to drain.
//   The cell chains shift by one slot per operation.
//   Reset clears the state, both counts and the output valid; cell contents
//   are don't-care until written. If the event receiver stalls, the single
//   output register holds its transfer and the sequencer waits before the next
//   one; a new command is taken only once the previous one has finished.
// ---------------------------------------------------------------------------
module job_admission_priority_queue_core #(
    parameter int WAIT_DEPTH  = japq_pkg::WAIT_DEPTH_DEF,
    parameter int RUN_DEPTH   = japq_pkg::RUN_DEPTH_DEF,
    parameter int ID_BITS     = japq_pkg::ID_BITS_DEF,
    parameter int HANDLE_BITS = japq_pkg::HANDLE_BITS_DEF,
    parameter int IN_DATA_W   = ((japq_pkg::MODE_W + ID_BITS + HANDLE_BITS
                                  + japq_pkg::PRIO_W + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // mode[2:0], job_id, job_handle, priority_req, zero fill
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [IN_DATA_W-1:0]              s_axis_tdata,
    // event_res[2:0], handle[18:3], zero fill
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [japq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [japq_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import japq_pkg::*;

    localparam int WI   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int RI   = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
    localparam int WC_W = $clog2(WAIT_DEPTH + 1);
    localparam int RC_W = $clog2(RUN_DEPTH + 1);
    localparam int LW   = RC_W + MAXRUN_W + 1;
    localparam int ID_LO  = MODE_W;
    localparam int HDL_LO = MODE_W + ID_BITS;
    localparam int PRI_LO = MODE_W + ID_BITS + HANDLE_BITS;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_CMP     = 5'b00010,
        S_EXEC    = 5'b00100,
        S_PROMOTE = 5'b01000,
        S_FLUSH   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [MAXRUN_W-1:0] r_max_running;
    logic [WC_W-1:0] r_wait_count, n_wait_count;
    logic [RC_W-1:0] r_run_count, n_run_count;

    logic [MODE_W-1:0]      r_key_mode;
    logic [ID_BITS-1:0]     r_key_id;
    logic [HANDLE_BITS-1:0] r_key_handle;
    logic [PRIO_W-1:0]      r_key_prio;

    logic [WAIT_DEPTH-1:0] r_w_hit;
    logic [RUN_DEPTH-1:0]  r_r_hit, r_r_hhit;
    logic [WC_W-1:0]       r_ins_pos;

    logic                 r_out_valid, n_out_valid;
    logic [EV_W-1:0]      r_out_ev, n_out_ev;
    logic [OUT_HDL_W-1:0] r_out_handle, n_out_handle;
    logic                 r_out_last, n_out_last;

    // chain cell taps
    logic [ID_BITS-1:0]     c_w_id     [WAIT_DEPTH];
    logic [HANDLE_BITS-1:0] c_w_handle [WAIT_DEPTH];
    logic [PRIO_W-1:0]      c_w_prio   [WAIT_DEPTH];
    logic [ID_BITS-1:0]     c_r_id     [RUN_DEPTH];
    logic [HANDLE_BITS-1:0] c_r_handle [RUN_DEPTH];
    logic [WAIT_DEPTH-1:0]  w_id_hit, w_prio_le, w_occ;
    logic [RUN_DEPTH-1:0]   run_id_hit, run_hdl_hit, run_occ;

    t_wop            w_op;
    logic [WI-1:0]   w_pos;
    t_rop            run_op;
    logic [RI-1:0]   run_pos;
    logic [ID_BITS-1:0]     run_new_id;
    logic [HANDLE_BITS-1:0] run_new_handle;

    logic out_free, emit;
    logic [EV_W-1:0] emit_ev;
    logic [HANDLE_BITS-1:0] emit_handle;
    logic emit_last;
    logic [WI-1:0] w_first;
    logic [RI-1:0] r_first, rh_first;
    logic [LW-1:0] rc_ext, rc1_ext, mr_ext, rd_ext;
    logic run_room, run_room_after;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAX_RUNNING) ? 32'(r_max_running) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_running <= MAXRUN_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_MAX_RUNNING)) begin
            r_max_running <= pwdata[MAXRUN_W-1:0];
        end
    end

    // ---------------- cell chains ----------------
    genvar k;
    generate
        for (k = 0; k < WAIT_DEPTH; k++) begin : g_wait
            localparam int L = (k > 0) ? k - 1 : 0;
            localparam int R = (k < WAIT_DEPTH - 1) ? k + 1 : k;
            japq_wait_cell #(
                .IDX(k), .PW(WI), .ID_BITS(ID_BITS), .HANDLE_BITS(HANDLE_BITS)
            ) u_cell (
                .i_clk          (i_clk),
                .i_op           (w_op),
                .i_pos          (w_pos),
                .i_new_id       (r_key_id),
                .i_new_handle   (r_key_handle),
                .i_new_prio     (r_key_prio),
                .i_left_id      (c_w_id[L]),
                .i_left_handle  (c_w_handle[L]),
                .i_left_prio    (c_w_prio[L]),
                .i_right_id     (c_w_id[R]),
                .i_right_handle (c_w_handle[R]),
                .i_right_prio   (c_w_prio[R]),
                .i_key_id       (r_key_id),
                .i_key_prio     (r_key_prio),
                .o_id           (c_w_id[k]),
                .o_handle       (c_w_handle[k]),
                .o_prio         (c_w_prio[k]),
                .o_id_hit       (w_id_hit[k]),
                .o_prio_le      (w_prio_le[k])
            );
            assign w_occ[k] = (WC_W'(k) < r_wait_count);
        end
        for (k = 0; k < RUN_DEPTH; k++) begin : g_run
            localparam int R = (k < RUN_DEPTH - 1) ? k + 1 : k;
            japq_run_cell #(
                .IDX(k), .PW(RI), .ID_BITS(ID_BITS), .HANDLE_BITS(HANDLE_BITS)
            ) u_cell (
                .i_clk          (i_clk),
                .i_op           (run_op),
                .i_pos          (run_pos),
                .i_new_id       (run_new_id),
                .i_new_handle   (run_new_handle),
                .i_right_id     (c_r_id[R]),
                .i_right_handle (c_r_handle[R]),
                .i_key_id       (r_key_id),
                .i_key_handle   (r_key_handle),
                .o_id           (c_r_id[k]),
                .o_handle       (c_r_handle[k]),
                .o_id_hit       (run_id_hit[k]),
                .o_handle_hit   (run_hdl_hit[k])
            );
            assign run_occ[k] = (RC_W'(k) < r_run_count);
        end
    endgenerate

    // promotion moves the waiting head into the running set
    assign run_new_id     = (r_state == S_PROMOTE) ? c_w_id[0] : r_key_id;
    assign run_new_handle = (r_state == S_PROMOTE) ? c_w_handle[0] : r_key_handle;

    // ---------------- capacity ----------------
    assign rc_ext  = LW'(r_run_count);
    assign rc1_ext = rc_ext + LW'(1);
    assign mr_ext  = LW'(r_max_running);
    assign rd_ext  = LW'(RUN_DEPTH);
    assign run_room       = (rc_ext < mr_ext) && (rc_ext < rd_ext);
    assign run_room_after = (rc1_ext < mr_ext) && (rc1_ext < rd_ext);

    // first match in list order
    always_comb begin
        w_first  = '0;
        r_first  = '0;
        rh_first = '0;
        for (int j = WAIT_DEPTH - 1; j >= 0; j--) begin
            if (r_w_hit[j]) w_first = WI'(j);
        end
        for (int j = RUN_DEPTH - 1; j >= 0; j--) begin
            if (r_r_hit[j])  r_first  = RI'(j);
            if (r_r_hhit[j]) rh_first = RI'(j);
        end
    end

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state      = r_state;
        n_wait_count = r_wait_count;
        n_run_count  = r_run_count;
        w_op         = WOP_HOLD;
        w_pos        = '0;
        run_op       = ROP_HOLD;
        run_pos      = '0;
        emit         = 1'b0;
        emit_ev      = EV_START;
        emit_handle  = r_key_handle;
        emit_last    = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                case (r_key_mode)
                    MODE_SUBMIT: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                            if ((|r_w_hit) || (|r_r_hit)) begin
                                emit_ev = EV_DUPE;
                            end else if (run_room) begin
                                emit_ev     = EV_START;
                                run_op      = ROP_PUSH;
                                run_pos     = r_run_count[RI-1:0];
                                n_run_count = r_run_count + RC_W'(1);
                            end else if (r_wait_count == WC_W'(WAIT_DEPTH)) begin
                                emit_ev = EV_FULL;
                            end else begin
                                emit_ev      = EV_QUEUED;
                                w_op         = WOP_INSERT;
                                w_pos        = r_ins_pos[WI-1:0];
                                n_wait_count = r_wait_count + WC_W'(1);
                            end
                        end
                    end
                    MODE_ABORT: begin
                        if (|r_w_hit) begin
                            if (out_free) begin
                                emit         = 1'b1;
                                emit_ev      = EV_ABORT_Q;
                                emit_handle  = c_w_handle[w_first];
                                w_op         = WOP_REMOVE;
                                w_pos        = w_first;
                                n_wait_count = r_wait_count - WC_W'(1);
                                n_state      = S_IDLE;
                            end
                        end else if (|r_r_hit) begin
                            if (out_free) begin
                                emit        = 1'b1;
                                emit_ev     = EV_ABORT_R;
                                emit_handle = c_r_handle[r_first];
                                run_op      = ROP_REMOVE;
                                run_pos     = r_first;
                                n_run_count = r_run_count - RC_W'(1);
                                n_state     = S_IDLE;
                            end
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    MODE_DONE: begin
                        if (|r_r_hhit) begin
                            run_op      = ROP_REMOVE;
                            run_pos     = rh_first;
                            n_run_count = r_run_count - RC_W'(1);
                        end
                        n_state = S_IDLE;
                    end
                    MODE_START:    n_state = S_PROMOTE;
                    MODE_SHUTDOWN: n_state = S_FLUSH;
                    default:       n_state = S_IDLE;
                endcase
            end
            S_PROMOTE: begin
                if ((r_wait_count != '0) && run_room) begin
                    if (out_free) begin
                        emit         = 1'b1;
                        emit_ev      = EV_START;
                        emit_handle  = c_w_handle[0];
                        emit_last    = !((r_wait_count > WC_W'(1)) && run_room_after);
                        w_op         = WOP_REMOVE;
                        run_op       = ROP_PUSH;
                        run_pos      = r_run_count[RI-1:0];
                        n_wait_count = r_wait_count - WC_W'(1);
                        n_run_count  = r_run_count + RC_W'(1);
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (r_wait_count != '0) begin
                    if (out_free) begin
                        emit         = 1'b1;
                        emit_ev      = EV_ABORT_Q;
                        emit_handle  = c_w_handle[0];
                        emit_last    = (r_wait_count == WC_W'(1)) && (r_run_count == '0);
                        w_op         = WOP_REMOVE;
                        n_wait_count = r_wait_count - WC_W'(1);
                    end
                end else if (r_run_count != '0) begin
                    if (out_free) begin
                        emit        = 1'b1;
                        emit_ev     = EV_ABORT_R;
                        emit_handle = c_r_handle[0];
                        emit_last   = (r_run_count == RC_W'(1));
                        run_op      = ROP_REMOVE;
                        n_run_count = r_run_count - RC_W'(1);
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_ev     = r_out_ev;
        n_out_handle = r_out_handle;
        n_out_last   = r_out_last;
        if (emit) begin
            n_out_valid  = 1'b1;
            n_out_ev     = emit_ev;
            n_out_handle = OUT_HDL_W'(emit_handle);
            n_out_last   = emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wait_count <= '0;
            r_run_count  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wait_count <= n_wait_count;
            r_run_count  <= n_run_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_ev     <= n_out_ev;
        r_out_handle <= n_out_handle;
        r_out_last   <= n_out_last;
        if (s_axis_tvalid && s_axis_tready) begin
            r_key_mode   <= s_axis_tdata[MODE_W-1:0];
            r_key_id     <= s_axis_tdata[ID_LO +: ID_BITS];
            r_key_handle <= s_axis_tdata[HDL_LO +: HANDLE_BITS];
            r_key_prio   <= s_axis_tdata[PRI_LO +: PRIO_W];
        end
        if (r_state == S_CMP) begin
            r_w_hit   <= w_id_hit & w_occ;
            r_r_hit   <= run_id_hit & run_occ;
            r_r_hhit  <= run_hdl_hit & run_occ;
            // list is sorted, so entries not above the key form a prefix
            r_ins_pos <= WC_W'($countones(w_prio_le & w_occ));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - OUT_HDL_W - EV_W)'(0), r_out_handle, r_out_ev};
    assign m_axis_tlast  = r_out_last;

endmodule

/* src/japq_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// japq_checker: port-level checks of the job queue core
// Watches the stream and APB ports over time.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module japq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        pready
);
    // no event transfer is pending right after reset
    `ASSERT_NEXT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n, !m_axis_tvalid)
    // one command at a time: not ready right after an accepted transfer
    `ASSERT_NEXT(a_one_cmd, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // stalled event holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    // config port never waits
    `ASSERT_NEXT(a_pready, i_clk, i_rst_n, 1'b1, pready)

endmodule

bind job_admission_priority_queue_core japq_checker u_japq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .pready        (pready)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: job admission priority queue core
// Drives command transfers, predicts the event transfers from a local
// copy of the waiting list and running set, and checks each event in order.
// ---------------------------------------------------------------------------
module testbench;
    import japq_pkg::*;

    localparam int WDEPTH    = 16;
    localparam int RDEPTH    = 16;
    localparam int IDLE_CY   = 40;
    localparam int LIMIT     = 600000;
    localparam int EVQ_DEPTH = 64;

    typedef struct packed {
        logic [EV_W-1:0] ev;
        logic [15:0]     hdl;
        logic            last;
    } t_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // mode, job_id, job_handle, priority, zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // event_res, handle, zero fill
    logic        m_axis_tlast;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    job_admission_priority_queue_core i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // local copy of the queue state
    logic [31:0] wait_id[WDEPTH];
    logic [15:0] wait_hdl[WDEPTH];
    logic [7:0]  wait_pri[WDEPTH];
    int          wait_cnt;
    logic [31:0] run_id[RDEPTH];
    logic [15:0] run_hdl[RDEPTH];
    int          run_cnt;
    int          max_run;

    // expected events, ring buffer
    t_event      ev_fifo[EVQ_DEPTH];
    int          ev_rd = 0;
    int          ev_wr = 0;
    int          ev_cnt = 0;
    logic [31:0] id_pool[24];
    int          errors;
    int          cycles;
    int          burst_left;
    int          hold_cycles;
    int          stall_level;

    function automatic void ev_put(logic [EV_W-1:0] ev, logic [15:0] hdl);
        ev_fifo[ev_wr] = t_event'{ev, hdl, 1'b0};
        ev_wr = (ev_wr + 1) % EVQ_DEPTH;
        ev_cnt++;
    endfunction

    function automatic t_event ev_take();
        t_event e;
        e = ev_fifo[ev_rd];
        ev_rd = (ev_rd + 1) % EVQ_DEPTH;
        ev_cnt--;
        return e;
    endfunction

    // event receiver: own stall pattern plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_axis_tready <= 1'b0;
        end else begin
            if (($urandom & 63) == 0) stall_level = $urandom_range(0, 3);
            m_axis_tready <= ($urandom_range(0, 3) >= stall_level);
        end
    end

    always @(posedge i_clk) begin
        t_event want;
        cycles++;
        if (cycles > LIMIT) begin
            $display("testbench failed");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (ev_cnt == 0) begin
                $error("unexpected event transfer ev=%0d handle=%h",
                       m_axis_tdata[2:0], m_axis_tdata[18:3]);
                errors++;
            end else begin
                want = ev_take();
                if (m_axis_tdata[2:0] !== want.ev) begin
                    $error("event_res: expected %0d, got %0d", want.ev, m_axis_tdata[2:0]);
                    errors++;
                end
                if (m_axis_tdata[18:3] !== want.hdl) begin
                    $error("handle: expected %h, got %h", want.hdl, m_axis_tdata[18:3]);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    function automatic void wait_drop(int pos);
        for (int i = pos; i + 1 < wait_cnt; i++) begin
            wait_id[i] = wait_id[i+1];
            wait_hdl[i] = wait_hdl[i+1];
            wait_pri[i] = wait_pri[i+1];
        end
        wait_cnt--;
    endfunction

    function automatic void run_drop(int pos);
        for (int i = pos; i + 1 < run_cnt; i++) begin
            run_id[i] = run_id[i+1];
            run_hdl[i] = run_hdl[i+1];
        end
        run_cnt--;
    endfunction

    function automatic void run_add(logic [31:0] id, logic [15:0] hdl);
        run_id[run_cnt] = id;
        run_hdl[run_cnt] = hdl;
        run_cnt++;
    endfunction

    // predict the events of one accepted command and update the state copy
    function automatic void predict_events(logic [2:0] mode, logic [31:0] id,
                                           logic [15:0] hdl, logic [7:0] pri);
        int     first_wr;
        int     cap;
        int     pos;
        bit     hit;
        first_wr = ev_wr;
        cap = (max_run < RDEPTH) ? max_run : RDEPTH;
        hit = 1'b0;
        case (mode)
            MODE_SUBMIT: begin
                for (int i = 0; i < wait_cnt; i++) if (wait_id[i] == id) hit = 1'b1;
                for (int i = 0; i < run_cnt; i++) if (run_id[i] == id) hit = 1'b1;
                if (hit) begin
                    ev_put(EV_DUPE, hdl);
                end else if (run_cnt < cap) begin
                    run_add(id, hdl);
                    ev_put(EV_START, hdl);
                end else if (wait_cnt >= WDEPTH) begin
                    ev_put(EV_FULL, hdl);
                end else begin
                    pos = 0;
                    while (pos < wait_cnt && wait_pri[pos] <= pri) pos++;
                    for (int i = wait_cnt; i > pos; i--) begin
                        wait_id[i] = wait_id[i-1];
                        wait_hdl[i] = wait_hdl[i-1];
                        wait_pri[i] = wait_pri[i-1];
                    end
                    wait_id[pos] = id;
                    wait_hdl[pos] = hdl;
                    wait_pri[pos] = pri;
                    wait_cnt++;
                    ev_put(EV_QUEUED, hdl);
                end
            end
            MODE_ABORT: begin
                for (int i = 0; i < wait_cnt && !hit; i++)
                    if (wait_id[i] == id) begin
                        ev_put(EV_ABORT_Q, wait_hdl[i]);
                        wait_drop(i);
                        hit = 1'b1;
                    end
                for (int i = 0; i < run_cnt && !hit; i++)
                    if (run_id[i] == id) begin
                        ev_put(EV_ABORT_R, run_hdl[i]);
                        run_drop(i);
                        hit = 1'b1;
                    end
            end
            MODE_DONE: begin
                for (int i = 0; i < run_cnt && !hit; i++)
                    if (run_hdl[i] == hdl) begin
                        run_drop(i);
                        hit = 1'b1;
                    end
            end
            MODE_START: begin
                while (wait_cnt > 0 && run_cnt < cap) begin
                    ev_put(EV_START, wait_hdl[0]);
                    run_add(wait_id[0], wait_hdl[0]);
                    wait_drop(0);
                end
            end
            MODE_SHUTDOWN: begin
                for (int i = 0; i < wait_cnt; i++) ev_put(EV_ABORT_Q, wait_hdl[i]);
                for (int i = 0; i < run_cnt; i++) ev_put(EV_ABORT_R, run_hdl[i]);
                wait_cnt = 0;
                run_cnt = 0;
            end
            default: ;
        endcase
        if (ev_wr != first_wr)
            ev_fifo[(ev_wr + EVQ_DEPTH - 1) % EVQ_DEPTH].last = 1'b1;
    endfunction

    task automatic send_cmd(logic [2:0] mode, logic [31:0] id, logic [15:0] hdl,
                            logic [7:0] pri);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, pri, hdl, id, mode};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_events(mode, id, hdl, pri);
    endtask

    task automatic sender_gap(int n);
        repeat (n) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    // bursty sender: random burst lengths, random gaps between them
    task automatic issue(logic [2:0] mode, logic [31:0] id, logic [15:0] hdl,
                         logic [7:0] pri);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            sender_gap($urandom_range(1, 6));
        end
        burst_left--;
        send_cmd(mode, id, hdl, pri);
    endtask

    task automatic drain_idle();
        sender_gap(1);
        wait (ev_cnt == 0);
        repeat (IDLE_CY) @(posedge i_clk);
    endtask

    task automatic write_max_running(logic [31:0] value);
        drain_idle();
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_MAX_RUNNING;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        max_run = value & 32'h1F;
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[MAXRUN_W-1:0] !== max_run[MAXRUN_W-1:0]) begin
            $error("max_running: expected %0d, got %0d", max_run, prdata[MAXRUN_W-1:0]);
            errors++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [31:0] pick_id();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return id_pool[$urandom_range(0, 23)];
    endfunction

    // mostly well-formed traffic: aborts and dones aimed at live jobs
    task automatic random_cmd();
        int          r;
        logic [31:0] id;
        logic [15:0] hdl;
        r = $urandom_range(0, 99);
        id = pick_id();
        hdl = 16'($urandom);
        if (r < 45) begin
            issue(MODE_SUBMIT, id, hdl, 8'($urandom));
        end else if (r < 62) begin
            if ($urandom_range(0, 3) != 0 && wait_cnt > 0 && $urandom_range(0, 1))
                id = wait_id[$urandom_range(0, wait_cnt - 1)];
            else if ($urandom_range(0, 3) != 0 && run_cnt > 0)
                id = run_id[$urandom_range(0, run_cnt - 1)];
            issue(MODE_ABORT, id, hdl, 8'($urandom));
        end else if (r < 80) begin
            if ($urandom_range(0, 4) != 0 && run_cnt > 0)
                hdl = run_hdl[$urandom_range(0, run_cnt - 1)];
            issue(MODE_DONE, id, hdl, 8'($urandom));
        end else if (r < 93) begin
            issue(MODE_START, id, hdl, 8'($urandom));
        end else if (r < 97) begin
            issue(MODE_SHUTDOWN, id, hdl, 8'($urandom));
        end else begin
            issue(3'($urandom_range(5, 7)), id, hdl, 8'($urandom));
        end
    endtask

    task automatic test_directed();
        send_cmd(MODE_SUBMIT, 32'h0, 16'h0000, 8'd0);
        send_cmd(MODE_SUBMIT, 32'hFFFF_FFFF, 16'hFFFF, 8'd255);
        send_cmd(MODE_SUBMIT, 32'h0, 16'h1234, 8'd7);          // duplicate of running
        send_cmd(MODE_SUBMIT, 32'h11, 16'h0011, 8'd5);
        send_cmd(MODE_SUBMIT, 32'h22, 16'h0022, 8'd5);         // fourth job starts, limit now reached
        send_cmd(MODE_SUBMIT, 32'h33, 16'h0033, 8'd255);       // queued
        send_cmd(MODE_SUBMIT, 32'h44, 16'h0044, 8'd0);         // jumps ahead
        send_cmd(MODE_SUBMIT, 32'h55, 16'h0055, 8'd255);       // tie, behind 0x33
        send_cmd(MODE_SUBMIT, 32'h44, 16'h4444, 8'd1);         // duplicate of queued
        send_cmd(MODE_ABORT, 32'h33, 16'h0, 8'd0);             // aborted while queued
        send_cmd(MODE_ABORT, 32'h11, 16'h0, 8'd0);             // aborted while running
        send_cmd(MODE_ABORT, 32'hDEAD_BEEF, 16'h0, 8'd0);      // unknown id
        send_cmd(MODE_DONE, 32'h0, 16'hFFFF, 8'd0);
        send_cmd(MODE_DONE, 32'h0, 16'hBEEF, 8'd0);            // unknown handle
        send_cmd(MODE_START, 32'h0, 16'h0, 8'd0);
        send_cmd(MODE_START, 32'h0, 16'h0, 8'd0);              // nothing to start
        send_cmd(3'd5, 32'h5, 16'h5, 8'd5);
        send_cmd(3'd6, 32'h6, 16'h6, 8'd6);
        send_cmd(3'd7, 32'h7, 16'h7, 8'd7);
        send_cmd(MODE_SHUTDOWN, 32'h0, 16'h0, 8'd0);
        send_cmd(MODE_SHUTDOWN, 32'h0, 16'h0, 8'd0);           // already empty
        drain_idle();
    endtask

    // zero capacity: everything waits until the list overflows, then limits 3 and 1
    task automatic test_queue_full();
        write_max_running(32'd0);
        for (int i = 0; i < WDEPTH + 2; i++)
            send_cmd(MODE_SUBMIT, 32'h100 + i, 16'($urandom), 8'($urandom_range(0, 3)));
        send_cmd(MODE_START, 32'h0, 16'h0, 8'd0);
        write_max_running(32'd3);
        send_cmd(MODE_START, 32'h0, 16'h0, 8'd0);
        write_max_running(32'd1);                              // limit below run count
        send_cmd(MODE_SUBMIT, 32'h200, 16'h0200, 8'd0);
        send_cmd(MODE_START, 32'h0, 16'h0, 8'd0);
        send_cmd(MODE_SHUTDOWN, 32'h0, 16'h0, 8'd0);
        drain_idle();
    endtask

    task automatic test_random(logic [31:0] limit, int count);
        write_max_running(limit);
        repeat (count) random_cmd();
        drain_idle();
    endtask

    // receiver holds off while commands keep coming
    task automatic test_backpressure();
        write_max_running(32'd16);
        hold_cycles = 400;
        for (int i = 0; i < 24; i++)
            send_cmd(MODE_SUBMIT, $urandom, 16'($urandom), 8'($urandom));
        send_cmd(MODE_SHUTDOWN, 32'h0, 16'h0, 8'd0);
        for (int i = 0; i < 6; i++)
            send_cmd(MODE_SUBMIT, $urandom, 16'($urandom), 8'($urandom));
        drain_idle();
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        burst_left = 0;
        hold_cycles = 0;
        stall_level = 0;
        wait_cnt = 0;
        run_cnt = 0;
        max_run = MAXRUN_RESET;
        foreach (id_pool[i]) id_pool[i] = $urandom;
        id_pool[0] = 32'h0;
        id_pool[1] = 32'hFFFF_FFFF;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_queue_full();
        test_random(32'd4, 50);
        test_random(32'd16, 50);
        test_random(32'd31, 40);
        test_random(32'd0, 30);
        test_random(32'd1, 50);
        test_random(32'd2, 50);
        test_backpressure();

        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/japq_pkg.sv
src/japq_wait_cell.sv
src/japq_run_cell.sv
src/job_admission_priority_queue_core.sv
src/japq_checker.sv
verif/testbench.sv
